### src/point_in_polygon_ray_cast_defines.svh
// Assertion helpers shared by the checkers of this block.
// Each macro expects clk and rst_n in scope.
`ifndef POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH
`define POINT_IN_POLYGON_RAY_CAST_DEFINES_SVH

// Same-cycle implication, quiet while reset is held
`define PIP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/pip_pkg.sv
`default_nettype none

package pip_pkg;

  // Storage and coordinate format
  localparam int MAX_VERTICES = 64;
  localparam int COORD_BITS   = 16;

  // Fixed field widths
  localparam int VIDX_W     = 6;
  localparam int VCOUNT_W   = 7;
  localparam int RAYLEN_W   = 15;
  localparam int CROSS_W    = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;
  localparam int CROSS_MAX  = 127;

  // Register reset values
  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = VCOUNT_W'(6);
  localparam logic [RAYLEN_W-1:0] RAYLEN_RESET = RAYLEN_W'(25600);

  // Step and crossing counters run 0..MAX_VERTICES
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int NW    = (CNT_W > VCOUNT_W) ? CNT_W : VCOUNT_W;

  // Edge arithmetic widths: differences, products, side values
  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int DPW = PW + 1;
  localparam int LSW = RAYLEN_W + 1;
  localparam int PLW = DW + LSW;
  localparam int RW  = ((DPW > PLW) ? DPW : PLW) + 1;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VERTEX_COUNT = 1'b0,
    CFG_RAY_LENGTH   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic                         kind;
    logic [VIDX_W-1:0]            vertex_index;
    logic signed [COORD_BITS-1:0] coord_x;
    logic signed [COORD_BITS-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic               inside_res;
    logic [CROSS_W-1:0] crossings;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
  } vertex_t;

  // Sequencer to edge unit: one edge to test, and end of sweep
  typedef struct packed {
    logic edge_valid;
    logic done;
  } edge_tag_t;

  // Edge unit to sequencer: verdict for one edge, and end of sweep
  typedef struct packed {
    logic edge_valid;
    logic hit;
    logic done;
  } edge_res_t;

endpackage

`default_nettype wire

### src/pip_cell.sv
`default_nettype none

module pip_cell import pip_pkg::*; (
  input  logic    clk,
  input  logic    load,
  input  logic    shift,
  input  vertex_t load_v,
  input  vertex_t next_v,
  output vertex_t v
);

  vertex_t v_r;

  // Take a written vertex, or the neighbour's vertex while the ring turns
  always_ff @(posedge clk) begin
    if (load) begin
      v_r <= load_v;
    end else if (shift) begin
      v_r <= next_v;
    end
  end

  assign v = v_r;

endmodule

`default_nettype wire

### src/pip_edge.sv
`default_nettype none

module pip_edge import pip_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  edge_tag_t                    tag,
  input  vertex_t                      v1,
  input  vertex_t                      v2,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic [RAYLEN_W-1:0]          len,
  output edge_res_t                    res
);

  edge_tag_t s1_tag_r, s2_tag_r, s3_tag_r, s4_tag_r;
  edge_res_t res_r;

  logic signed [DW-1:0]  s1_dy_nxt, s1_dx_nxt, s1_ex_nxt, s1_ey_nxt, ey2;
  logic signed [DW-1:0]  s1_dy_r, s1_dx_r, s1_ex_r, s1_ey_r;
  logic signed [DW-1:0]  s2_dy_r, s2_dx_r, s2_ey_r;
  logic signed [DW-1:0]  s3_dy_r;
  logic signed [PW-1:0]  s2_pa_nxt, s2_pa_r, prod_b;
  logic signed [DPW-1:0] s3_dp_nxt, s3_dp_r, s4_dp_r;
  logic signed [LSW-1:0] len_s;
  logic signed [PLW-1:0] prod_l;
  logic signed [RW-1:0]  s4_dr_nxt, s4_dr_r;
  logic                  s1_ssy_nxt, s1_ssy_r, s2_ssy_r, s3_ssy_r, s4_ssy_r;
  logic                  ey_pos, ey_neg, ey2_pos, ey2_neg;
  logic                  dp_pos, dp_neg, dr_pos, dr_neg, hit_nxt;

  // Stage 1: coordinate differences and the sides of the edge ends against the ray line
  assign s1_dy_nxt = DW'(v2.y) - DW'(v1.y);
  assign s1_dx_nxt = DW'(v2.x) - DW'(v1.x);
  assign s1_ex_nxt = DW'(px) - DW'(v1.x);
  assign s1_ey_nxt = DW'(py) - DW'(v1.y);
  assign ey2       = DW'(py) - DW'(v2.y);

  assign ey_neg  = s1_ey_nxt[DW-1];
  assign ey_pos  = !s1_ey_nxt[DW-1] && (|s1_ey_nxt);
  assign ey2_neg = ey2[DW-1];
  assign ey2_pos = !ey2[DW-1] && (|ey2);

  // A zero-length ray puts every side value at zero
  assign s1_ssy_nxt = (len != '0) && ((ey_pos && ey2_pos) || (ey_neg && ey2_neg));

  // Stage 2: first cross-product term
  assign s2_pa_nxt = PW'(s1_dy_r) * PW'(s1_ex_r);

  // Stage 3: side of the ray start against the edge line
  assign prod_b    = PW'(s2_dx_r) * PW'(s2_ey_r);
  assign s3_dp_nxt = DPW'(s2_pa_r) - DPW'(prod_b);

  // Stage 4: side of the ray end, start value moved along by the ray length
  assign len_s     = signed'({1'b0, len});
  assign prod_l    = PLW'(s3_dy_r) * PLW'(len_s);
  assign s4_dr_nxt = RW'(s3_dp_r) + RW'(prod_l);

  // Stage 5: both tests must see the ends on opposite sides, or touching
  assign dp_neg  = s4_dp_r[DPW-1];
  assign dp_pos  = !s4_dp_r[DPW-1] && (|s4_dp_r);
  assign dr_neg  = s4_dr_r[RW-1];
  assign dr_pos  = !s4_dr_r[RW-1] && (|s4_dr_r);
  assign hit_nxt = !s4_ssy_r && !((dp_pos && dr_pos) || (dp_neg && dr_neg));

  // Advance the tags; clear on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
      s3_tag_r <= '0;
      s4_tag_r <= '0;
      res_r    <= '0;
    end else begin
      s1_tag_r         <= tag;
      s2_tag_r         <= s1_tag_r;
      s3_tag_r         <= s2_tag_r;
      s4_tag_r         <= s3_tag_r;
      res_r.edge_valid <= s4_tag_r.edge_valid;
      res_r.done       <= s4_tag_r.done;
      res_r.hit        <= hit_nxt;
    end
  end

  // Advance the arithmetic
  always_ff @(posedge clk) begin
    s1_dy_r  <= s1_dy_nxt;
    s1_dx_r  <= s1_dx_nxt;
    s1_ex_r  <= s1_ex_nxt;
    s1_ey_r  <= s1_ey_nxt;
    s1_ssy_r <= s1_ssy_nxt;

    s2_pa_r  <= s2_pa_nxt;
    s2_dy_r  <= s1_dy_r;
    s2_dx_r  <= s1_dx_r;
    s2_ey_r  <= s1_ey_r;
    s2_ssy_r <= s1_ssy_r;

    s3_dp_r  <= s3_dp_nxt;
    s3_dy_r  <= s2_dy_r;
    s3_ssy_r <= s2_ssy_r;

    s4_dr_r  <= s4_dr_nxt;
    s4_dp_r  <= s3_dp_r;
    s4_ssy_r <= s3_ssy_r;
  end

  assign res = res_r;

endmodule

`default_nettype wire

### src/point_in_polygon_ray_cast.sv
// Channel   Handshake             Payload      Direction
// in        in_valid / in_stall   in_item_t    into the block
// out       out_valid / out_stall out_item_t   out of the block
// cfg       cfg_we                cfg_index, cfg_wdata   into the block
//
// A vertex write leaves the input open. A query closes it until its result is
// in the output register: the vertex ring makes one full turn of MAX_VERTICES + 1
// steps, one edge per step into a five-stage edge unit, whatever vertex_count
// holds. Synchronous reset sets vertex_count to 6 and ray_length to 25600; the
// vertex ring is not cleared. in_stall stays high while a query runs or its
// result waits for the output register.
`default_nettype none

module point_in_polygon_ray_cast import pip_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic [VCOUNT_W-1:0]          vertex_count_r;
  logic [RAYLEN_W-1:0]          ray_length_r;
  logic [CNT_W-1:0]             step_r, cnt_r, cnt_nxt, n_use;
  logic [NW-1:0]                n_wide, cnt_wide;
  logic signed [COORD_BITS-1:0] qx_r, qy_r;
  vertex_t                      prev_r, first_r, head, wr_v, edge_v2;
  logic                         out_valid_r, out_free;
  out_item_t                    out_item_r;
  logic [CROSS_W-1:0]           cross_sat;
  logic                         in_acc, q_start, wr_en, running, last_step, wrap, shift;
  logic [MAX_VERTICES-1:0]      wr_sel;
  vertex_t                      ring_v [MAX_VERTICES];
  edge_tag_t                    tag;
  edge_res_t                    res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_count_r <= VCOUNT_RESET;
      ray_length_r   <= RAYLEN_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VERTEX_COUNT: vertex_count_r <= cfg_wdata[VCOUNT_W-1:0];
        CFG_RAY_LENGTH:   ray_length_r   <= cfg_wdata[RAYLEN_W-1:0];
        default:          ;
      endcase
    end
  end

  // Input handshake and item decode
  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign q_start  = in_acc && (in_item.kind == KIND_QUERY);
  assign wr_en    = in_acc && (in_item.kind == KIND_WRITE);
  assign wr_v     = '{x: in_item.coord_x, y: in_item.coord_y};

  // Vertex ring: cell 0 is the head, every cell takes from the one above, the top cell from cell 0
  for (genvar gi = 0; gi < MAX_VERTICES; gi++) begin : g_ring
    assign wr_sel[gi] = wr_en && (int'(in_item.vertex_index) == gi);

    pip_cell u_cell (
      .clk    (clk),
      .load   (wr_sel[gi]),
      .shift  (shift),
      .load_v (wr_v),
      .next_v (ring_v[(gi + 1) % MAX_VERTICES]),
      .v      (ring_v[gi])
    );
  end

  assign head = ring_v[0];

  // Edges in use, capped at the ring size
  assign n_wide = NW'(vertex_count_r);
  assign n_use  = (n_wide > NW'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : CNT_W'(n_wide);

  // Sweep control: step k pairs vertex k-1 with vertex k, or with vertex 0 at the wrap
  assign running   = (state_r == S_RUN);
  assign last_step = (step_r == CNT_W'(MAX_VERTICES));
  assign shift     = running && !last_step;
  assign wrap      = (step_r == n_use);
  assign edge_v2   = wrap ? first_r : head;

  assign tag.edge_valid = running &&
                          (((step_r != '0) && (step_r < n_use)) || (wrap && (n_use != '0)));
  assign tag.done       = running && last_step;

  pip_edge u_edge (
    .clk   (clk),
    .rst_n (rst_n),
    .tag   (tag),
    .v1    (prev_r),
    .v2    (edge_v2),
    .px    (qx_r),
    .py    (qy_r),
    .len   (ray_length_r),
    .res   (res)
  );

  // Count crossings as verdicts come back
  assign cnt_nxt = cnt_r + CNT_W'(res.edge_valid && res.hit);

  // Saturate the reported count; parity comes from the true count
  assign cnt_wide  = NW'(cnt_r);
  assign cross_sat = (cnt_wide > NW'(CROSS_MAX)) ? CROSS_W'(CROSS_MAX) : CROSS_W'(cnt_wide);
  assign out_free  = !out_valid_r || !out_stall;

  // Hold the query point and the trailing vertices of the sweep
  always_ff @(posedge clk) begin
    if (q_start) begin
      qx_r <= in_item.coord_x;
      qy_r <= in_item.coord_y;
    end
    if (shift) begin
      prev_r <= head;
      if (step_r == '0) begin
        first_r <= head;
      end
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_start) begin
            step_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          cnt_r <= cnt_nxt;
          if (last_step) begin
            state_r <= S_DRAIN;
          end else begin
            step_r <= step_r + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          cnt_r <= cnt_nxt;
          if (res.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r           <= 1'b1;
            out_item_r.inside_res <= cnt_r[0];
            out_item_r.crossings  <= cross_sat;
            state_r               <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### src/pip_check.sv
`default_nettype none
`include "point_in_polygon_ray_cast_defines.svh"

module pip_check import pip_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  // A held result keeps its payload
  `PIP_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item), "result changed while stalled")

  // A query closes the input until its sweep is over
  `PIP_ASSERT_NEXT(a_query_busy, in_valid && !in_stall && (in_item.kind == KIND_QUERY), in_stall, "input open after query")

  // A vertex write leaves the input open
  `PIP_ASSERT_NEXT(a_write_quick, in_valid && !in_stall && (in_item.kind == KIND_WRITE), !in_stall, "input closed after write")

  // Parity agrees with the count and the count fits the ring
  `PIP_ASSERT_NOW(a_out_sane, out_valid, (out_item.inside_res == out_item.crossings[0]) && (int'(out_item.crossings) <= MAX_VERTICES), "bad result")

endmodule

bind point_in_polygon_ray_cast pip_check u_pip_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import pip_pkg::*;

  localparam int STIM_ITEMS    = 1660;
  localparam int SETTLE_CYCLES = 80;
  localparam int TAIL_CYCLES   = 100;
  localparam int HOLD_CYCLES   = 500;
  localparam int HOLD_AT       = 300;
  localparam int STEADY_FROM   = 900;
  localparam int STEADY_TO     = 1200;
  localparam int IDLE_PCT      = 35;

  typedef enum logic [1:0] {STEP_CFG, STEP_ITEM, STEP_KNOWN} step_op_t;

  // One row of the directed plan: a register setting, or an item with or
  // without a verdict written out by hand
  typedef struct {
    step_op_t            op;
    logic [VCOUNT_W-1:0] vcount;
    logic [RAYLEN_W-1:0] raylen;
    in_item_t            item;
    out_item_t           verdict;
  } step_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_VERTEX_COUNT;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Shadow of the polygon and the registers
  logic signed [COORD_BITS-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] poly_y [MAX_VERTICES];
  logic [VCOUNT_W-1:0]          poly_count = VCOUNT_RESET;
  logic [RAYLEN_W-1:0]          ray_len    = RAYLEN_RESET;

  out_item_t expected_verdicts [$];
  step_t     directed_plan [$];
  out_item_t due;
  int        errors        = 0;
  int        items_sent    = 0;
  int        hold_left     = 0;
  bit        hold_done     = 1'b0;
  bit        steady;

  point_in_polygon_ray_cast dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  assign steady = (items_sent >= STEADY_FROM) && (items_sent < STEADY_TO);

  function automatic int side_sign(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic bit same_side(input int a, input int b);
    return (a > 0 && b > 0) || (a < 0 && b < 0);
  endfunction

  // Count the edges that the ray from (px,py) crosses or touches
  function automatic out_item_t ray_verdict(input logic signed [COORD_BITS-1:0] px,
                                            input logic signed [COORD_BITS-1:0] py);
    out_item_t verdict;
    int        n;
    int        j;
    int        hits;
    longint    x1, y1, x2, y2, len, dp, dr;
    n    = (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    hits = 0;
    len  = longint'(ray_len);
    for (int i = 0; i < n; i++) begin
      j  = (i + 1 == n) ? 0 : i + 1;
      x1 = longint'(poly_x[i]);
      y1 = longint'(poly_y[i]);
      x2 = longint'(poly_x[j]);
      y2 = longint'(poly_y[j]);
      // edge endpoints against the ray's line
      if (len != 0 && same_side(side_sign(py - y1), side_sign(py - y2)))
        continue;
      // ray endpoints against the edge's line
      dp = (y2 - y1) * (px - x1) - (x2 - x1) * (py - y1);
      dr = dp + (y2 - y1) * len;
      if (same_side(side_sign(dp), side_sign(dr)))
        continue;
      hits++;
    end
    verdict.inside_res = hits[0];
    verdict.crossings  = (hits > CROSS_MAX) ? CROSS_W'(CROSS_MAX) : CROSS_W'(hits);
    return verdict;
  endfunction

  function automatic logic [COORD_BITS-1:0] clip16(input int v);
    if (v > 32767)
      return 16'sh7FFF;
    if (v < -32768)
      return 16'sh8000;
    return COORD_BITS'(v);
  endfunction

  function automatic int rand_off(input int spread);
    return int'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic in_item_t put_item(input int idx, input logic [COORD_BITS-1:0] x,
                                        input logic [COORD_BITS-1:0] y);
    in_item_t it;
    it.kind         = KIND_WRITE;
    it.vertex_index = VIDX_W'(idx);
    it.coord_x      = x;
    it.coord_y      = y;
    return it;
  endfunction

  function automatic in_item_t query_item(input logic [COORD_BITS-1:0] x,
                                          input logic [COORD_BITS-1:0] y);
    in_item_t it;
    it.kind         = KIND_QUERY;
    it.vertex_index = VIDX_W'($urandom);
    it.coord_x      = x;
    it.coord_y      = y;
    return it;
  endfunction

  function automatic step_t cfg_step(input int vc, input int rl);
    step_t s;
    s.op      = STEP_CFG;
    s.vcount  = VCOUNT_W'(vc);
    s.raylen  = RAYLEN_W'(rl);
    s.item    = '0;
    s.verdict = '0;
    return s;
  endfunction

  function automatic step_t put_step(input int idx, input int x, input int y);
    step_t s;
    s      = cfg_step(0, 0);
    s.op   = STEP_ITEM;
    s.item = put_item(idx, clip16(x), clip16(y));
    return s;
  endfunction

  function automatic step_t ask_step(input int x, input int y);
    step_t s;
    s      = cfg_step(0, 0);
    s.op   = STEP_ITEM;
    s.item = query_item(clip16(x), clip16(y));
    return s;
  endfunction

  function automatic step_t ask_known(input int x, input int y, input bit ins, input int cr);
    step_t s;
    s                   = ask_step(x, y);
    s.op                = STEP_KNOWN;
    s.item.vertex_index = '1;
    s.verdict.inside_res = ins;
    s.verdict.crossings  = CROSS_W'(cr);
    return s;
  endfunction

  // Append one row to the directed plan
  function automatic void add_step(input step_t s);
    directed_plan.insert(directed_plan.size(), s);
  endfunction

  // Queue one verdict for the result side
  function automatic void expect_verdict(input out_item_t v);
    expected_verdicts.insert(expected_verdicts.size(), v);
  endfunction

  // Offer one item with random gaps ahead of it outside the steady window, hold it
  // until accepted, then update the shadow state
  task automatic offer_item(input in_item_t item, input bit known,
                            input out_item_t known_verdict);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    items_sent++;
    if (item.kind == KIND_WRITE) begin
      poly_x[item.vertex_index] = item.coord_x;
      poly_y[item.vertex_index] = item.coord_y;
    end else if (known) begin
      expect_verdict(known_verdict);
    end else begin
      expect_verdict(ray_verdict(item.coord_x, item.coord_y));
    end
  endtask

  // Drop valid and wait until the block has drained
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_registers(input logic [VCOUNT_W-1:0] vc, input logic [RAYLEN_W-1:0] rl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_VERTEX_COUNT;
    cfg_wdata <= CFG_DATA_W'(vc);
    @(posedge clk);
    cfg_index <= CFG_RAY_LENGTH;
    cfg_wdata <= CFG_DATA_W'(rl);
    @(posedge clk);
    cfg_we     <= 1'b0;
    poly_count = vc;
    ray_len    = rl;
  endtask

  // Result side: check each accepted item, then stall at random or hold off
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_verdicts.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got inside %0d crossings %0d",
                 $time, out_item.inside_res, out_item.crossings);
      end else begin
        due = expected_verdicts.pop_front();
        if (out_item.inside_res !== due.inside_res) begin
          errors++;
          $display("%0t: inside_res expected %0d, got %0d",
                   $time, due.inside_res, out_item.inside_res);
        end
        if (out_item.crossings !== due.crossings) begin
          errors++;
          $display("%0t: crossings expected %0d, got %0d",
                   $time, due.crossings, out_item.crossings);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && items_sent >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin : stimulus
    int                  pick;
    int                  used;
    int                  slot;
    int                  cx;
    int                  cy;
    int                  spread;
    logic [VCOUNT_W-1:0] vc;
    logic [RAYLEN_W-1:0] rl;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill every slot so that no query ever reads an unwritten vertex
    for (int k = 0; k < MAX_VERTICES; k++)
      offer_item(put_item(k, clip16(rand_off(4000)), clip16(rand_off(4000))), 1'b0, '0);

    // Directed plan: reset settings, a square, touching, extremes, degenerate counts
    add_step(ask_step(0, 0));
    add_step(put_step(0, -160, -160));
    add_step(put_step(1, 160, -160));
    add_step(put_step(2, 160, 160));
    add_step(put_step(3, -160, 160));
    add_step(cfg_step(4, 25600));
    add_step(ask_known(0, 0, 1'b1, 1));
    add_step(ask_known(320, 0, 1'b0, 0));
    add_step(ask_known(-320, 0, 1'b0, 2));
    add_step(ask_step(0, 160));
    add_step(ask_step(160, 0));
    add_step(ask_step(32767, 32767));
    add_step(ask_step(-32768, -32768));
    add_step(ask_step(-32768, 0));
    add_step(ask_step(32767, -32768));
    add_step(cfg_step(4, 0));
    add_step(ask_known(0, 0, 1'b0, 0));
    add_step(ask_step(160, 0));
    add_step(cfg_step(0, 32767));
    add_step(ask_known(0, 0, 1'b0, 0));
    add_step(cfg_step(1, 1));
    add_step(ask_step(-160, -160));
    add_step(cfg_step(2, 32767));
    add_step(ask_step(-1000, -160));
    add_step(cfg_step(127, 25600));
    add_step(ask_step(0, 0));
    add_step(put_step(0, 32767, -32768));
    add_step(put_step(63, -32768, 32767));
    add_step(cfg_step(64, 32767));
    add_step(ask_step(-32768, 0));
    add_step(cfg_step(3, 1));
    add_step(ask_step(0, 0));

    foreach (directed_plan[i]) begin
      if (directed_plan[i].op == STEP_CFG) begin
        settle();
        set_registers(directed_plan[i].vcount, directed_plan[i].raylen);
      end else begin
        offer_item(directed_plan[i].item, directed_plan[i].op == STEP_KNOWN,
                   directed_plan[i].verdict);
      end
    end

    // Random phases: new settings, a fresh polygon when it is small or at random, then mostly queries around it
    while (items_sent < STIM_ITEMS) begin
      pick = $urandom_range(0, 19);
      if (pick < 12)
        vc = VCOUNT_W'($urandom_range(3, 12));
      else if (pick < 14)
        vc = VCOUNT_W'($urandom_range(0, 2));
      else if (pick == 14)
        vc = VCOUNT_W'(MAX_VERTICES);
      else if (pick == 15)
        vc = '1;
      else
        vc = VCOUNT_W'($urandom);
      pick = $urandom_range(0, 9);
      if (pick == 0)
        rl = '0;
      else if (pick == 1)
        rl = '1;
      else if (pick == 2)
        rl = RAYLEN_W'(1);
      else
        rl = RAYLEN_W'($urandom_range(1, 32767));
      settle();
      set_registers(vc, rl);

      used   = (vc > MAX_VERTICES) ? MAX_VERTICES : int'(vc);
      cx     = int'($urandom_range(0, 32000)) - 16000;
      cy     = int'($urandom_range(0, 32000)) - 16000;
      spread = $urandom_range(16, 8000);
      if (used <= 16 || $urandom_range(0, 3) == 0)
        for (int k = 0; k < used; k++)
          offer_item(put_item(k, clip16(cx + rand_off(spread)),
                              clip16(cy + rand_off(spread))), 1'b0, '0);

      repeat ($urandom_range(20, 80)) begin
        pick = $urandom_range(0, 15);
        slot = (used == 0) ? 0 : $urandom_range(0, used - 1);
        if (pick < 2)
          offer_item(put_item(int'($urandom), COORD_BITS'($urandom), COORD_BITS'($urandom)),
                     1'b0, '0);
        else if (pick < 4)
          offer_item(query_item(COORD_BITS'($urandom), COORD_BITS'($urandom)), 1'b0, '0);
        else if (pick < 6)
          offer_item(query_item(clip16(cx + rand_off(spread * 3 / 2)), poly_y[slot]),
                     1'b0, '0);
        else if (pick == 6)
          offer_item(query_item(poly_x[slot], poly_y[slot]), 1'b0, '0);
        else
          offer_item(query_item(clip16(cx + rand_off(spread * 3 / 2)),
                                clip16(cy + rand_off(spread * 3 / 2))), 1'b0, '0);
      end
    end

    // Drain and let the block run on for a while
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && expected_verdicts.size() == 0) begin
      $display("point_in_polygon_ray_cast test passed");
    end else begin
      $display("point_in_polygon_ray_cast test failed");
    end
    $finish;
  end

  // Abort a run that hangs
  initial begin
    #20_000_000;
    $display("point_in_polygon_ray_cast test failed");
    $finish;
  end

endmodule
